// ===== rtl/rmw_pkg.sv =====
// ----------------------------------------------------------------------------
// rmw_pkg
// Shared widths, types and constants of the rolling mean window block.
// ----------------------------------------------------------------------------
package rmw_pkg;

    localparam int WIN_MAX   = 64;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 7;
    localparam int CNT_OUT_W = 7;
    localparam int PTR_W     = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
    localparam int CNT_W     = $clog2(WIN_MAX + 1);
    localparam int SUM_W     = DATA_W + PTR_W;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);
    localparam int WIN_RESET = (10 > WIN_MAX) ? WIN_MAX : 10;

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SUB   = 5'b00010,
        ST_START = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [SUM_W-1:0] mag;
        logic [CNT_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                     busy;
        logic signed [DATA_W-1:0] quo;
    } t_div_rsp;

endpackage

// ===== rtl/rmw_ram.sv =====
// ----------------------------------------------------------------------------
// rmw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rmw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rmw_div.sv =====
// ----------------------------------------------------------------------------
// rmw_div
// Radix-2 restoring divider: sum magnitude by sample count, one quotient
// bit per cycle, sign applied to the truncated quotient.
// ----------------------------------------------------------------------------
module rmw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rmw_pkg::t_div_req i_req,
    output rmw_pkg::t_div_rsp o_rsp
);

    localparam int SW = rmw_pkg::SUM_W;
    localparam int CW = rmw_pkg::CNT_W;
    localparam int DW = rmw_pkg::DATA_W;
    localparam int KW = rmw_pkg::DIV_CNT_W;

    logic          r_busy;
    logic [KW-1:0] r_cnt;
    logic [SW-1:0] r_q;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_den;
    logic          r_neg;

    logic [CW:0]   shifted;
    logic          ge;
    logic [CW:0]   diff;
    logic [DW-1:0] q_low;

    assign shifted = {r_rem, r_q[SW-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= KW'(SW - 1);
            r_q   <= i_req.mag;
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_cnt <= r_cnt - KW'(1);
            r_q   <= {r_q[SW-2:0], ge};
            // remainder stays below the divisor, top bit is always clear
            r_rem <= ge ? diff[CW-1:0] : shifted[CW-1:0];
        end
    end

    assign q_low       = r_q[DW-1:0];
    assign o_rsp.busy  = r_busy;
    assign o_rsp.quo   = r_neg ? $signed(-q_low) : $signed(q_low);

endmodule

// ===== rtl/rolling_mean_window_core.sv =====
// ----------------------------------------------------------------------------
// rolling_mean_window_core
// Moving average over the most recent samples, ring held in block RAM.
// ----------------------------------------------------------------------------
// Input (i_in_valid / o_in_ready): func selects push (sample stored, oldest
//   dropped once the window is full) or clear (store emptied). Output
//   (o_out_valid / i_out_ready): one transaction per input with mean,
//   mean_valid and sample_count. Config (i_cfg_valid / o_cfg_ready): window
//   size; a nonzero write saturates to the ring depth and empties the store,
//   a zero write is dropped. Config is taken only while idle.
// Timing: a push loads the result register once the serial divider, one bit
//   per cycle over the 38-bit sum, has finished (with a full window, the
//   oldest sample is read back from the ring first). A clear skips the
//   divider. The next item is taken once the result has loaded and the
//   block is back in idle.
//   With the receiver stalled one more item is taken and parks its result
//   until the output register frees; the input then stays not ready.
// Reset: synchronous active-low; window returns to 10, store is empty. The
//   ring RAM is not cleared: only entries holding stored samples are read.
// ----------------------------------------------------------------------------
module rolling_mean_window_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rmw_pkg::CFG_W-1:0]            i_cfg_window_size,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_func,
    input  logic signed [rmw_pkg::DATA_W-1:0]    i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rmw_pkg::DATA_W-1:0]    o_mean,
    output logic                                 o_mean_valid,
    output logic [rmw_pkg::CNT_OUT_W-1:0]        o_sample_count
);

    localparam int DW = rmw_pkg::DATA_W;
    localparam int PW = rmw_pkg::PTR_W;
    localparam int CW = rmw_pkg::CNT_W;
    localparam int SW = rmw_pkg::SUM_W;

    rmw_pkg::t_state         r_state, n_state;
    logic [CW-1:0]           r_window, n_window;
    logic [CW-1:0]           r_count, n_count;
    logic [PW-1:0]           r_oldest, n_oldest;
    logic signed [SW-1:0]    r_sum, n_sum;
    logic [PW-1:0]           r_slot, n_slot;
    logic [DW-1:0]           r_sample, n_sample;
    logic signed [DW-1:0]    r_mean, n_mean;
    logic                    r_out_valid, n_out_valid;
    logic signed [DW-1:0]    r_out_mean, n_out_mean;
    logic                    r_out_mvalid, n_out_mvalid;
    logic [CW-1:0]           r_out_count, n_out_count;

    logic                    in_acc;
    logic                    cfg_acc;
    logic                    full;
    logic [CW:0]             slot_raw;
    logic [PW-1:0]           slot;
    logic [PW-1:0]           oldest_inc;
    logic [CW-1:0]           cfg_sat;

    logic                    ram_we;
    logic [PW-1:0]           ram_waddr;
    logic [DW-1:0]           ram_wdata;
    logic [DW-1:0]           ram_rdata;

    rmw_pkg::t_div_req       div_req;
    rmw_pkg::t_div_rsp       div_rsp;

    assign o_cfg_ready = (r_state == rmw_pkg::ST_IDLE);
    assign o_in_ready  = (r_state == rmw_pkg::ST_IDLE) && !i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && o_in_ready;

    assign full = r_count >= r_window;

    // ring slot after the newest sample, wrapped at the ring depth
    assign slot_raw = {1'b0, CW'(r_oldest)} + {1'b0, r_count};
    assign slot     = (slot_raw >= (CW+1)'(rmw_pkg::WIN_MAX))
                    ? PW'(slot_raw - (CW+1)'(rmw_pkg::WIN_MAX)) : PW'(slot_raw);
    assign oldest_inc = (r_oldest == PW'(rmw_pkg::WIN_MAX - 1)) ? '0 : r_oldest + PW'(1);

    assign cfg_sat = (32'(i_cfg_window_size) > 32'(rmw_pkg::WIN_MAX))
                   ? CW'(rmw_pkg::WIN_MAX) : CW'(i_cfg_window_size);

    always_comb begin
        n_state      = r_state;
        n_window     = r_window;
        n_count      = r_count;
        n_oldest     = r_oldest;
        n_sum        = r_sum;
        n_slot       = r_slot;
        n_sample     = r_sample;
        n_mean       = r_mean;
        n_out_valid  = r_out_valid;
        n_out_mean   = r_out_mean;
        n_out_mvalid = r_out_mvalid;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = slot;
        ram_wdata    = i_sample;
        div_req.start = 1'b0;
        div_req.neg   = r_sum[SW-1];
        div_req.mag   = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
        div_req.den   = r_count;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            rmw_pkg::ST_IDLE: begin
                if (cfg_acc && i_cfg_window_size != '0) begin
                    n_window = cfg_sat;
                    n_count  = '0;
                    n_oldest = '0;
                    n_sum    = '0;
                end else if (in_acc) begin
                    if (i_func == rmw_pkg::FUNC_CLEAR) begin
                        n_count  = '0;
                        n_oldest = '0;
                        n_sum    = '0;
                        n_state  = rmw_pkg::ST_START;
                    end else begin
                        n_sum    = r_sum + SW'(i_sample);
                        n_slot   = slot;
                        n_sample = i_sample;
                        if (full) begin
                            // oldest entry is being read out of the ring now
                            n_state = rmw_pkg::ST_SUB;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + CW'(1);
                            n_state = rmw_pkg::ST_START;
                        end
                    end
                end
            end
            rmw_pkg::ST_SUB: begin
                n_sum     = r_sum - SW'($signed(ram_rdata));
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = r_sample;
                n_oldest  = oldest_inc;
                n_state   = rmw_pkg::ST_START;
            end
            rmw_pkg::ST_START: begin
                if (r_count == '0) begin
                    n_mean  = '0;
                    n_state = rmw_pkg::ST_DONE;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = rmw_pkg::ST_WAIT;
                end
            end
            rmw_pkg::ST_WAIT: begin
                if (!div_rsp.busy) begin
                    n_mean  = div_rsp.quo;
                    n_state = rmw_pkg::ST_DONE;
                end
            end
            rmw_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_mean   = r_mean;
                    n_out_mvalid = (r_count != '0);
                    n_out_count  = r_count;
                    n_state      = rmw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmw_pkg::ST_IDLE;
            r_window    <= CW'(rmw_pkg::WIN_RESET);
            r_count     <= '0;
            r_oldest    <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_count     <= n_count;
            r_oldest    <= n_oldest;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_sample     <= n_sample;
        r_mean       <= n_mean;
        r_out_mean   <= n_out_mean;
        r_out_mvalid <= n_out_mvalid;
        r_out_count  <= n_out_count;
    end

    rmw_ram #(
        .WIDTH (DW),
        .DEPTH (rmw_pkg::WIN_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_oldest),
        .o_rdata (ram_rdata)
    );

    rmw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out_valid    = r_out_valid;
    assign o_mean         = r_out_mean;
    assign o_mean_valid   = r_out_mvalid;
    assign o_sample_count = rmw_pkg::CNT_OUT_W'(r_out_count);

`ifndef SYNTHESIS
    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_window)
        else $error("stored count exceeds window");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != rmw_pkg::ST_IDLE)
        else $error("input transaction did not start work");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_mvalid) |-> (r_out_mean == '0 && r_out_count == '0))
        else $error("empty result carries nonzero mean or count");

    a_mvalid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_mvalid == (r_out_count != '0)))
        else $error("mean_valid disagrees with sample count");

    a_div_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
`endif

endmodule
